// ===== design/rbei_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the rigid body integrator.
package rbei_pkg;

	localparam int VAL_W     = 32;
	localparam int FRAC_BITS = 16;
	localparam int FRIC_BITS = 16;
	localparam int MS_W      = 10;
	localparam int FRIC_W    = 17;
	localparam int MAG_W     = 48;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int LANES     = 6;

	// x / 1000 as (x * RECIP_HI) >> 38, exact for x < 2^32
	localparam logic [9:0]  DIV_MS          = 10'd1000;
	localparam logic [28:0] RECIP_HI        = 29'd274877907;
	localparam int          RECIP_HI_SHIFT  = 38;
	localparam int          QM_W            = 22;
	// y / 1000 as (y * RECIP_LO) >> 30, exact for y < 2^20
	localparam logic [20:0] RECIP_LO        = 21'd1073742;
	localparam int          RECIP_LO_SHIFT  = 30;
	localparam int          T2_W            = 20;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] MAG_VMAX = {{(MAG_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};

	// register indexes (word address)
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_GRAVITY  = 3'd1;
	localparam logic [2:0] REG_GACCEL   = 3'd2;
	localparam logic [2:0] REG_FRICTION = 3'd3;
	localparam logic [2:0] REG_INVMASS  = 3'd4;

	localparam logic                     RST_ENABLE   = 1'b0;
	localparam logic                     RST_GRAVITY  = 1'b1;
	localparam logic signed [VAL_W-1:0]  RST_GACCEL   = -32'sd642253;
	localparam logic [FRIC_W-1:0]        RST_FRICTION = 17'd65536;
	localparam logic [31:0]              RST_INVMASS  = 32'd65536;

	typedef struct packed {
		logic                    enable;
		logic                    gravity_on;
		logic signed [VAL_W-1:0] gravity_accel;
		logic [FRIC_W-1:0]       friction_factor;
		logic [31:0]             inverse_mass;
	} cfg_t;

	typedef struct packed {
		logic [MS_W-1:0]  delta_ms;
		logic             contact;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
	} tick_t;

	typedef struct packed {
		logic signed [31:0] lin_pos_x;
		logic signed [31:0] lin_pos_y;
		logic signed [31:0] lin_pos_z;
		logic signed [31:0] ang_pos_x;
		logic signed [31:0] ang_pos_y;
		logic signed [31:0] ang_pos_z;
		logic signed [31:0] lin_vel_x;
		logic signed [31:0] lin_vel_y;
		logic signed [31:0] lin_vel_z;
		logic signed [31:0] ang_vel_x;
		logic signed [31:0] ang_vel_y;
		logic signed [31:0] ang_vel_z;
	} result_t;

	// sign and magnitude back to a saturated signed value
	function automatic logic signed [VAL_W-1:0] from_mag(input logic neg,
		input logic [MAG_W-1:0] mag);
		logic signed [VAL_W-1:0] r;
		if (!neg) begin
			r = (mag > MAG_VMAX) ? VAL_MAX : VAL_W'(mag);
		end else begin
			r = (mag > MAG_VMAX) ? VAL_MIN : -VAL_W'(mag);
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sadd(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] s;
		logic signed [VAL_W-1:0] r;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			r = s[VAL_W] ? VAL_MIN : VAL_MAX;
		end else begin
			r = s[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/rbei_regs.sv =====
// Configuration register file behind the APB-style port.
module rbei_regs import rbei_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= RST_ENABLE;
			cfg_q.gravity_on      <= RST_GRAVITY;
			cfg_q.gravity_accel   <= RST_GACCEL;
			cfg_q.friction_factor <= RST_FRICTION;
			cfg_q.inverse_mass    <= RST_INVMASS;
		end else if (wr) begin
			case (idx)
				REG_ENABLE:   cfg_q.enable          <= pwdata[0];
				REG_GRAVITY:  cfg_q.gravity_on      <= pwdata[0];
				REG_GACCEL:   cfg_q.gravity_accel   <= pwdata[VAL_W-1:0];
				REG_FRICTION: cfg_q.friction_factor <= pwdata[FRIC_W-1:0];
				REG_INVMASS:  cfg_q.inverse_mass    <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE:   prdata = DATA_W'(cfg_q.enable);
			REG_GRAVITY:  prdata = DATA_W'(cfg_q.gravity_on);
			REG_GACCEL:   prdata = DATA_W'(unsigned'(cfg_q.gravity_accel));
			REG_FRICTION: prdata = DATA_W'(cfg_q.friction_factor);
			REG_INVMASS:  prdata = DATA_W'(cfg_q.inverse_mass);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== design/rbei_lane.sv =====
// One axis lane: acceleration, velocity and position update with a stepped datapath.
module rbei_lane import rbei_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    gate,
	input  logic [MS_W-1:0]         delta_ms,
	input  logic signed [VAL_W-1:0] drive,
	input  logic                    grav_lane,
	input  cfg_t                    cfg,
	output logic                    busy,
	output logic signed [VAL_W-1:0] pos,
	output logic signed [VAL_W-1:0] vel
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_DQ   = 3'd3;
	localparam logic [2:0] ST_DP   = 3'd4;
	localparam logic [2:0] ST_DS   = 3'd5;

	logic [2:0] st_q;
	logic fric_ph_q;   // multiply step applies friction instead of inverse mass
	logic pos_ph_q;    // divide steps produce the position increment
	logic signed [VAL_W-1:0] v_q, p_q;

	logic signed [VAL_W-1:0] x_q;
	logic neg_q, gate_q;
	logic [MS_W-1:0] ms_q;
	logic [63:0] prod_q;
	logic [QM_W-1:0] qm_q;
	logic [31:0] mag_q;
	logic [31:0] t1_q;
	logic [T2_W-1:0] t2_q;

	logic x_neg;
	logic [31:0] x_mag, mul_b, rm_full;
	logic [63:0] prod, sh;
	logic signed [VAL_W-1:0] norm, acc_g, res, v_new, p_new;
	logic [60:0] qm_prod;
	logic [40:0] t3_prod;
	logic [MS_W-1:0] rm;
	logic [32:0] sum;

	assign x_neg = x_q[VAL_W-1];
	assign x_mag = x_neg ? 32'(-x_q) : 32'(x_q);
	assign mul_b = fric_ph_q ? 32'(cfg.friction_factor) : cfg.inverse_mass;
	assign prod  = 64'(x_mag) * 64'(mul_b);

	assign sh    = fric_ph_q ? (prod_q >> FRIC_BITS) : (prod_q >> FRAC_BITS);
	assign norm  = from_mag(neg_q, sh[MAG_W-1:0]);
	assign acc_g = (grav_lane & cfg.gravity_on) ? sadd(norm, cfg.gravity_accel) : norm;

	// magnitude * ms / 1000 split as q*ms + (r*ms)/1000 with q, r = mag div/mod 1000
	assign qm_prod = 61'(x_mag) * 61'(RECIP_HI);
	assign rm_full = mag_q - 32'(qm_q) * 32'(DIV_MS);
	assign rm      = rm_full[MS_W-1:0];
	assign t3_prod = 41'(t2_q) * 41'(RECIP_LO);
	assign sum     = 33'(t1_q) + 33'(t3_prod[RECIP_LO_SHIFT +: MS_W]);
	assign res     = from_mag(neg_q, MAG_W'(sum));
	assign v_new   = sadd(v_q, res);
	assign p_new   = sadd(p_q, res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			fric_ph_q <= 1'b0;
			pos_ph_q  <= 1'b0;
			v_q       <= '0;
			p_q       <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						fric_ph_q <= 1'b0;
						pos_ph_q  <= 1'b0;
						st_q      <= ST_MUL;
					end
				end
				ST_MUL:  st_q <= ST_NORM;
				ST_NORM: begin
					if (fric_ph_q) begin
						v_q      <= norm;
						pos_ph_q <= 1'b1;
					end
					st_q <= ST_DQ;
				end
				ST_DQ: st_q <= ST_DP;
				ST_DP: st_q <= ST_DS;
				ST_DS: begin
					if (pos_ph_q) begin
						p_q  <= p_new;
						st_q <= ST_IDLE;
					end else if (gate_q) begin
						fric_ph_q <= 1'b1;
						st_q      <= ST_MUL;
					end else begin
						v_q      <= v_new;
						pos_ph_q <= 1'b1;
						st_q     <= ST_DQ;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (start) begin
					x_q    <= gate ? drive : '0;
					gate_q <= gate;
					ms_q   <= delta_ms;
				end
			end
			ST_MUL: begin
				prod_q <= prod;
				neg_q  <= x_neg;
			end
			ST_NORM: x_q <= fric_ph_q ? norm : acc_g;
			ST_DQ: begin
				qm_q  <= qm_prod[RECIP_HI_SHIFT +: QM_W];
				mag_q <= x_mag;
				neg_q <= x_neg;
			end
			ST_DP: begin
				t1_q <= 32'(qm_q) * 32'(ms_q);
				t2_q <= T2_W'(rm) * T2_W'(ms_q);
			end
			ST_DS: begin
				if (!pos_ph_q) begin
					x_q <= v_new;
				end
			end
			default: ;
		endcase
	end

	assign busy = (st_q != ST_IDLE);
	assign pos  = p_q;
	assign vel  = v_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == ST_IDLE)
		else $error("lane started while busy");

	a_pos_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DS && pos_ph_q) |=> st_q == ST_IDLE)
		else $error("position step did not finish the tick");

	a_fric_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE && fric_ph_q) |-> gate_q)
		else $error("friction applied without contact gate");

	a_no_mul_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL) |-> !pos_ph_q)
		else $error("multiply step entered during position phase");
`endif

endmodule

// ===== design/rigid_body_euler_integrator_top.sv =====
// Top level of the rigid body semi-implicit Euler integrator.
//
// Usage: program the registers over the APB-style port while idle, then send one
// tick per transfer on tick_valid/tick_stall. Each tick yields one result transfer
// on result_valid/result_stall carrying positions and velocities after the tick.
// Six lanes (linear x/y/z, angular x/y/z) run the same step sequence side by side
// and the output register gathers their state once all six are done.
// When contact is set or gravity is off, a friction multiply adds two lane
// steps (multiply, normalize); with enable clear the lanes do not run at all.
// Lane step order: mass scaling multiply, normalize, a three-step divide-by-1000
// pass for velocity, the friction multiply and normalize when gated, then a
// three-step pass for position. One tick is worked at a time; tick_stall is
// high from acceptance until the result is loaded.
// A finished result is held in the output register while the receiver stalls,
// and the next tick may be accepted meanwhile; the lanes then wait to unload.
// Reset clears all motion state to zero and loads register defaults
// (enable 0, gravity on, gravity -9.8 in Q16.16, friction 1.0, inverse mass 1.0).
module rigid_body_euler_integrator_top import rbei_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	cfg_t cfg;
	logic busy_q;
	logic result_valid_q;
	result_t result_q;

	logic accept, start, gate, done;
	logic [LANES-1:0] lane_busy;
	logic signed [VAL_W-1:0] lane_in  [LANES];
	logic signed [VAL_W-1:0] lane_pos [LANES];
	logic signed [VAL_W-1:0] lane_vel [LANES];

	rbei_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready     = 1'b1;
	assign tick_stall = busy_q;
	assign accept     = tick_valid & ~busy_q;
	assign start      = accept & cfg.enable;
	assign gate       = tick.contact | ~cfg.gravity_on;

	assign lane_in[0] = tick.force_x;
	assign lane_in[1] = tick.force_y;
	assign lane_in[2] = tick.force_z;
	assign lane_in[3] = tick.torque_x;
	assign lane_in[4] = tick.torque_y;
	assign lane_in[5] = tick.torque_z;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rbei_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (start),
			.gate      (gate),
			.delta_ms  (tick.delta_ms),
			.drive     (lane_in[i]),
			.grav_lane ((i == 1) ? 1'b1 : 1'b0),
			.cfg       (cfg),
			.busy      (lane_busy[i]),
			.pos       (lane_pos[i]),
			.vel       (lane_vel[i])
		);
	end

	// lanes are all idle and the output register is free to take the tick's state
	assign done = busy_q & ~(|lane_busy) & (~result_valid_q | ~result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				result_valid_q <= 1'b1;
			end else if (~result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			result_q.lin_pos_x <= lane_pos[0];
			result_q.lin_pos_y <= lane_pos[1];
			result_q.lin_pos_z <= lane_pos[2];
			result_q.ang_pos_x <= lane_pos[3];
			result_q.ang_pos_y <= lane_pos[4];
			result_q.ang_pos_z <= lane_pos[5];
			result_q.lin_vel_x <= lane_vel[0];
			result_q.lin_vel_y <= lane_vel[1];
			result_q.lin_vel_z <= lane_vel[2];
			result_q.ang_vel_x <= lane_vel[3];
			result_q.ang_vel_y <= lane_vel[4];
			result_q.ang_vel_z <= lane_vel[5];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_lanes_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_busy) |-> busy_q)
		else $error("lane running outside a tick");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> $stable(result_q))
		else $error("stalled result overwritten");

	a_start_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (&lane_busy))
		else $error("lanes did not all start together");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the rigid body Euler integrator: directed table, then random ticks.
module tb;
	import rbei_pkg::*;

	localparam longint          V_HI       = 64'sd2147483647;
	localparam longint          V_LO       = -64'sd2147483648;
	localparam longint unsigned MAG_CAP    = 64'd2147483647;
	localparam int              N_FIELDS   = 12;
	localparam int              RES_W      = $bits(result_t);
	localparam int              PHASES     = 8;
	localparam int              PHASE_LEN  = 155;
	localparam int              HOLD_CYCLES = 60;
	localparam int              TIMEOUT_NS = 6000000;

	typedef enum logic {STEP_CFG, STEP_TICK} step_kind_e;

	typedef struct {
		step_kind_e  kind;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		tick_t       item;
		bit          typed;
		result_t     want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              tick_valid;
	logic              tick_stall;
	tick_t             tick;
	logic              result_valid;
	logic              result_stall;
	result_t           result;

	// predictor copy of the body and its registers
	cfg_t   body_cfg;
	longint lin_vel[3];
	longint ang_vel[3];
	longint lin_pos[3];
	longint ang_pos[3];

	result_t   body_states_due[$];
	plan_row_t plan[$];
	int        err_count;
	int        gap_pct;
	int        stall_pct;
	int        hold_requests;
	bit        quiet;

	string field_names[N_FIELDS] = '{"lin_pos_x", "lin_pos_y", "lin_pos_z",
		"ang_pos_x", "ang_pos_y", "ang_pos_z", "lin_vel_x", "lin_vel_y", "lin_vel_z",
		"ang_vel_x", "ang_vel_y", "ang_vel_z"};

	rigid_body_euler_integrator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint sat_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > V_HI) return V_HI;
		if (s < V_LO) return V_LO;
		return s;
	endfunction

	// trunc(a * b >> shift / div), saturated; the product always fits in 64 bits here
	function automatic longint scale_q(input longint a, input longint unsigned b,
		input int shift, input longint unsigned div);
		bit              neg;
		longint unsigned prod;
		neg  = a < 0;
		prod = neg ? longint'(-a) : longint'(a);
		prod = prod * b;
		prod = prod >> shift;
		prod = prod / div;
		if (!neg) return (prod > MAG_CAP) ? V_HI : longint'(prod);
		return (prod > MAG_CAP) ? V_LO : -longint'(prod);
	endfunction

	function automatic void advance_axis(inout longint vel, inout longint pos,
		input longint acc, input longint unsigned ms, input bit gate);
		longint v;
		v = sat_add(vel, scale_q(acc, ms, 0, 64'd1000));
		if (gate) v = scale_q(v, 64'(body_cfg.friction_factor), FRIC_BITS, 64'd1);
		vel = v;
		pos = sat_add(pos, scale_q(v, ms, 0, 64'd1000));
	endfunction

	function automatic result_t advance_body(input tick_t t);
		result_t         r;
		bit              gate;
		longint          frc[3];
		longint          trq[3];
		longint          la;
		longint          aa;
		longint unsigned ms;
		int              i;
		gate = t.contact || !body_cfg.gravity_on;
		ms   = 64'(t.delta_ms);
		frc  = '{longint'(t.force_x), longint'(t.force_y), longint'(t.force_z)};
		trq  = '{longint'(t.torque_x), longint'(t.torque_y), longint'(t.torque_z)};
		if (body_cfg.enable) begin
			for (i = 0; i < 3; i++) begin
				la = gate ? scale_q(frc[i], 64'(body_cfg.inverse_mass), FRAC_BITS, 64'd1) : 0;
				aa = gate ? scale_q(trq[i], 64'(body_cfg.inverse_mass), FRAC_BITS, 64'd1) : 0;
				if (i == 1 && body_cfg.gravity_on)
					la = sat_add(la, longint'(body_cfg.gravity_accel));
				advance_axis(lin_vel[i], lin_pos[i], la, ms, gate);
				advance_axis(ang_vel[i], ang_pos[i], aa, ms, gate);
			end
		end
		r.lin_pos_x = 32'(lin_pos[0]);
		r.lin_pos_y = 32'(lin_pos[1]);
		r.lin_pos_z = 32'(lin_pos[2]);
		r.ang_pos_x = 32'(ang_pos[0]);
		r.ang_pos_y = 32'(ang_pos[1]);
		r.ang_pos_z = 32'(ang_pos[2]);
		r.lin_vel_x = 32'(lin_vel[0]);
		r.lin_vel_y = 32'(lin_vel[1]);
		r.lin_vel_z = 32'(lin_vel[2]);
		r.ang_vel_x = 32'(ang_vel[0]);
		r.ang_vel_y = 32'(ang_vel[1]);
		r.ang_vel_z = 32'(ang_vel[2]);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_result(input result_t got);
		result_t           want;
		logic signed [31:0] g;
		logic signed [31:0] w;
		int                k;
		if (body_states_due.size() == 0) begin
			flag_mismatch("result transfer with no tick outstanding");
		end else begin
			want = body_states_due.pop_front();
			for (k = 0; k < N_FIELDS; k++) begin
				g = got[RES_W-1-32*k -: 32];
				w = want[RES_W-1-32*k -: 32];
				if (g !== w) flag_mismatch($sformatf("%s got %0d want %0d", field_names[k], g, w));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) check_result(result);
	end

	// receiver stalls: random bursts, plus a long hold-off on request
	initial begin : rx_stall
		int hold_left;
		int burst_left;
		int served;
		hold_left    = 0;
		burst_left   = 0;
		served       = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served    = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(99) < stall_pct) begin
				burst_left = $urandom_range(1, 5) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic program_reg(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_ENABLE:   body_cfg.enable          = v[0];
			REG_GRAVITY:  body_cfg.gravity_on      = v[0];
			REG_GACCEL:   body_cfg.gravity_accel   = v;
			REG_FRICTION: body_cfg.friction_factor = v[FRIC_W-1:0];
			REG_INVMASS:  body_cfg.inverse_mass    = v;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_tick(input tick_t t, input bit typed, input result_t want);
		result_t due;
		@(negedge clk);
		tick_valid <= 1'b1;
		tick       <= t;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		due = advance_body(t);
		body_states_due.push_back(typed ? want : due);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		tick_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain_body();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (body_states_due.size() != 0) @(posedge clk);
	endtask

	function automatic tick_t mk_tick(input logic [MS_W-1:0] ms, input logic c,
		input logic signed [31:0] fx, input logic signed [31:0] fy,
		input logic signed [31:0] fz, input logic signed [31:0] tx,
		input logic signed [31:0] ty, input logic signed [31:0] tz);
		tick_t t;
		t.delta_ms = ms;
		t.contact  = c;
		t.force_x  = fx;
		t.force_y  = fy;
		t.force_z  = fz;
		t.torque_x = tx;
		t.torque_y = ty;
		t.torque_z = tz;
		return t;
	endfunction

	function automatic void plan_tick(input tick_t t, input bit typed, input result_t want);
		plan_row_t row;
		row.kind    = STEP_TICK;
		row.reg_idx = REG_ENABLE;
		row.value   = '0;
		row.item    = t;
		row.typed   = typed;
		row.want    = want;
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(input logic [2:0] idx, input logic [31:0] v);
		plan_row_t row;
		row.kind    = STEP_CFG;
		row.reg_idx = idx;
		row.value   = v;
		row.item    = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		plan.push_back(row);
	endfunction

	// mostly moderate magnitudes so motion is not always pinned at the rails
	function automatic logic signed [31:0] rand_q();
		logic [31:0] m;
		int          sh;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return VAL_MAX;
			2: return VAL_MIN;
			default: begin
				sh = $urandom_range(4, 26);
				m  = $urandom & ((32'd1 << sh) - 32'd1);
				return $urandom_range(1) ? -m : m;
			end
		endcase
	endfunction

	function automatic tick_t rand_tick();
		logic [MS_W-1:0] ms;
		case ($urandom_range(0, 9))
			0: ms = 10'($urandom_range(0, 1023));
			1: ms = 10'($urandom_range(0, 16));
			2: ms = 10'($urandom_range(1000, 1023));
			default: ms = 10'($urandom_range(0, 1000));
		endcase
		return mk_tick(ms, 1'($urandom_range(1)), rand_q(), rand_q(), rand_q(),
			rand_q(), rand_q(), rand_q());
	endfunction

	function automatic logic [31:0] junk_above(input int lsb);
		return ($urandom_range(3) == 0) ? ($urandom << lsb) : 32'd0;
	endfunction

	task automatic pick_setup(input int p);
		logic        en;
		logic [31:0] v;
		en = (p == 3) ? 1'b0 : ($urandom_range(9) != 0);
		program_reg(REG_ENABLE, junk_above(1) | 32'(en));
		program_reg(REG_GRAVITY, junk_above(1) | 32'($urandom_range(1)));
		case ($urandom_range(0, 5))
			0: v = RST_GACCEL;
			1: v = $urandom;
			2: v = VAL_MAX;
			3: v = VAL_MIN;
			default: v = $urandom_range(1) ? -32'($urandom_range(0, 1 << 20))
				: 32'($urandom_range(0, 1 << 20));
		endcase
		program_reg(REG_GACCEL, v);
		case ($urandom_range(0, 5))
			0: v = 32'(RST_FRICTION);
			1: v = 32'd0;
			2: v = 32'h0001_FFFF;
			3: v = 32'($urandom_range(0, 131071));
			default: v = 32'($urandom_range(58000, 65536));
		endcase
		program_reg(REG_FRICTION, junk_above(FRIC_W) | v);
		case ($urandom_range(0, 6))
			0: v = RST_INVMASS;
			1: v = $urandom;
			2: v = 32'd0;
			3: v = 32'hFFFF_FFFF;
			4: v = 32'($urandom_range(1, 255));
			default: v = 32'($urandom_range(1, 1 << 18));
		endcase
		program_reg(REG_INVMASS, v);
		case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 35;
		endcase
		case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 15;
			default: stall_pct = 40;
		endcase
	endtask

	initial begin : stim
		result_t fell;
		int      i;
		int      p;
		int      n;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		tick_valid    = 1'b0;
		tick          = '0;
		err_count     = 0;
		gap_pct       = 0;
		stall_pct     = 0;
		hold_requests = 0;
		quiet         = 1'b0;
		body_cfg.enable          = RST_ENABLE;
		body_cfg.gravity_on      = RST_GRAVITY;
		body_cfg.gravity_accel   = RST_GACCEL;
		body_cfg.friction_factor = RST_FRICTION;
		body_cfg.inverse_mass    = RST_INVMASS;
		for (i = 0; i < 3; i++) begin
			lin_vel[i] = 0;
			ang_vel[i] = 0;
			lin_pos[i] = 0;
			ang_pos[i] = 0;
		end

		// one second of free fall from rest
		fell           = '0;
		fell.lin_pos_y = RST_GACCEL;
		fell.lin_vel_y = RST_GACCEL;

		// disabled after reset: state stays at zero
		plan_tick(mk_tick(10'd1023, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN,
			VAL_MIN), 1'b1, '0);
		plan_tick(mk_tick(10'd0, 1'b0, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX,
			VAL_MAX), 1'b1, '0);
		plan_cfg(REG_ENABLE, 32'd1);
		plan_tick(mk_tick(10'd0, 1'b0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX), 1'b1, '0);
		// no contact with gravity on: force and torque gated off
		plan_tick(mk_tick(10'd1000, 1'b0, 32'sh0001_0000, VAL_MAX, VAL_MIN,
			32'sh0002_0000, VAL_MIN, VAL_MAX), 1'b1, fell);
		plan_tick(mk_tick(10'd1000, 1'b1, 32'sh0001_0000, 32'sh000A_0000, -32'sh0003_8000,
			32'sh0000_4000, -32'sh0001_0000, 32'sh0002_0000), 1'b0, '0);
		// tick over one second, pushed into saturation
		plan_tick(mk_tick(10'd1023, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN,
			VAL_MIN), 1'b0, '0);
		plan_tick(mk_tick(10'd1023, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN,
			VAL_MIN), 1'b0, '0);
		plan_tick(mk_tick(10'd1, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX,
			VAL_MAX), 1'b0, '0);
		plan_cfg(REG_INVMASS, 32'd0);
		plan_tick(mk_tick(10'd500, 1'b1, VAL_MAX, VAL_MIN, 32'sh1234_5678,
			-32'sh0765_4321, VAL_MAX, VAL_MIN), 1'b0, '0);
		plan_cfg(REG_INVMASS, 32'hFFFF_FFFF);
		plan_tick(mk_tick(10'd1000, 1'b1, 32'sd1, -32'sd1, 32'sd0, 32'sd2, -32'sd3,
			32'sh0000_0100), 1'b0, '0);
		// friction above one
		plan_cfg(REG_FRICTION, 32'h0001_FFFF);
		plan_cfg(REG_INVMASS, RST_INVMASS);
		plan_tick(mk_tick(10'd250, 1'b1, 32'sh0004_0000, -32'sh0002_0000, 32'sh0000_8000,
			32'sh0001_0000, 32'sh0003_0000, -32'sh0000_4000), 1'b0, '0);
		plan_tick(mk_tick(10'd999, 1'b1, -32'sh0100_0000, 32'sh0080_0000, 32'sh00FF_FFFF,
			-32'sh0000_0001, 32'sh7000_0000, -32'sh7000_0000), 1'b0, '0);
		// gravity off opens the gate; zero friction stops everything
		plan_cfg(REG_GRAVITY, 32'd0);
		plan_cfg(REG_FRICTION, 32'd0);
		plan_tick(mk_tick(10'd777, 1'b0, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
			-32'sh0005_0000, -32'sh0005_0000, -32'sh0005_0000), 1'b0, '0);
		plan_cfg(REG_FRICTION, 32'h0000_8000);
		plan_cfg(REG_GRAVITY, 32'd1);
		plan_cfg(REG_GACCEL, 32'h7FFF_FFFF);
		plan_tick(mk_tick(10'd1000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0),
			1'b0, '0);
		plan_cfg(REG_GACCEL, 32'h8000_0000);
		plan_tick(mk_tick(10'd1000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0),
			1'b0, '0);
		plan_tick(mk_tick(10'd1023, 1'b1, 32'sh0010_0000, 32'sh0010_0000, -32'sh0010_0000,
			32'sh0000_1000, -32'sh0000_1000, 32'sh0000_0010), 1'b0, '0);
		plan_cfg(REG_ENABLE, 32'd0);
		plan_tick(mk_tick(10'd600, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX), 1'b0, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[k]) begin
			if (plan[k].kind == STEP_CFG) begin
				drain_body();
				program_reg(plan[k].reg_idx, plan[k].value);
			end else begin
				send_tick(plan[k].item, plan[k].typed, plan[k].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			drain_body();
			pick_setup(p);
			quiet = (p == PHASES - 1);
			for (n = 0; n < PHASE_LEN; n++) begin
				// long receiver hold-off while ticks keep coming
				if (p == 1 && n == 20) hold_requests++;
				if (p == 2 && n == 60) drain_body();
				send_tick(rand_tick(), 1'b0, '0);
				if (!quiet && $urandom_range(99) < gap_pct) pause_sender($urandom_range(1, 5));
			end
		end

		drain_body();
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== rigid_body_euler_integrator_top.f =====
design/rbei_pkg.sv
design/rbei_regs.sv
design/rbei_lane.sv
design/rigid_body_euler_integrator_top.sv
sim/tb.sv
